/* hdl/mcmf_pkg.sv */
`default_nettype none

package mcmf_pkg;

    localparam int unsigned GROUP_BYTES = 4;
    localparam int unsigned GI_W        = $clog2(GROUP_BYTES);
    localparam int unsigned SUM_W       = 17;

    localparam logic [2:0] REQ_COPY  = 3'd0;
    localparam logic [2:0] REQ_MOVE  = 3'd1;
    localparam logic [2:0] REQ_FILL  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } t_result;

endpackage

`default_nettype wire

/* hdl/memory_copy_move_fill_engine.sv */
`default_nettype none

// channel   valid          ready          payload
// request   i_req_valid    o_req_ready    i_req_type i_dst_addr i_src_addr i_length
//                                         i_fill_byte i_write_byte
// response  o_rsp_valid    i_rsp_ready    o_read_data o_status
//
// one request beat at a time; a byte store with one write and one read port sets the pace
// copy works in 4-byte groups plus single tail bytes; a backward move goes byte by byte;
// rejected or empty commands stop at the first range check, or at the second when only
// the source range runs past the store or a move lands on itself
// after reset a clearing pass zeroes the store, no request taken
// the response register holds one finished beat while the next request is worked

module memory_copy_move_fill_engine #(
    parameter int unsigned MEM_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    output logic             o_req_ready,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [11:0] i_dst_addr,
    input  wire logic [11:0] i_src_addr,
    input  wire logic [12:0] i_length,
    input  wire logic [7:0]  i_fill_byte,
    input  wire logic [7:0]  i_write_byte,
    output logic             o_rsp_valid,
    input  wire logic        i_rsp_ready,
    output logic      [7:0]  o_read_data,
    output logic             o_status
);

    import mcmf_pkg::*;

    localparam int unsigned AW = $clog2(MEM_BYTES);

    logic          res_valid;
    logic          res_ready;
    t_result       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    logic          r_out_valid;
    t_result       r_out;

    mcmf_seq #(
        .MEM_BYTES(MEM_BYTES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req_type   (i_req_type),
        .i_dst_addr   (i_dst_addr),
        .i_src_addr   (i_src_addr),
        .i_length     (i_length),
        .i_fill_byte  (i_fill_byte),
        .i_write_byte (i_write_byte),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    mcmf_ram #(
        .DEPTH(MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // response register
    assign res_ready = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_read_data = r_out.read_data;
    assign o_status    = r_out.status;

endmodule

`default_nettype wire

/* hdl/mcmf_ram.sv */
`default_nettype none

module mcmf_ram #(
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/mcmf_seq.sv */
`default_nettype none

module mcmf_seq #(
    parameter int unsigned MEM_BYTES = 4096,
    localparam int unsigned AW       = $clog2(MEM_BYTES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire logic [2:0]        i_req_type,
    input  wire logic [11:0]       i_dst_addr,
    input  wire logic [11:0]       i_src_addr,
    input  wire logic [12:0]       i_length,
    input  wire logic [7:0]        i_fill_byte,
    input  wire logic [7:0]        i_write_byte,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output mcmf_pkg::t_result      o_res,
    output logic                   o_mem_we,
    output logic      [AW-1:0]     o_mem_waddr,
    output logic      [7:0]        o_mem_wdata,
    output logic                   o_mem_re,
    output logic      [AW-1:0]     o_mem_raddr,
    input  wire logic [7:0]        i_mem_rdata
);

    import mcmf_pkg::*;

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_CHK1 = 11'b000_0000_0100,
        S_CHK2 = 11'b000_0000_1000,
        S_RD   = 11'b000_0001_0000,
        S_WR   = 11'b000_0010_0000,
        S_FILL = 11'b000_0100_0000,
        S_RB   = 11'b000_1000_0000,
        S_RBW  = 11'b001_0000_0000,
        S_WB   = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [2:0]  r_req;
    logic [11:0] r_dst;
    logic [11:0] r_src;
    logic [12:0] r_len;
    logic [7:0]  r_fill;
    logic [7:0]  r_wbyte;
    logic [12:0] r_rd_off;
    logic [12:0] r_wr_off;
    logic [12:0] r_left;
    logic [2:0]  r_j;
    logic        r_grp;
    logic        r_bwd;
    logic [7:0]  r_held [GROUP_BYTES];
    logic [AW-1:0] r_clr;
    t_result     r_res;

    logic [11:0]      add_a;
    logic [12:0]      add_b;
    logic [SUM_W-1:0] sum;
    logic             past_end;
    logic             op_block;
    logic             op_single;
    logic             op_nop;
    logic             go_bwd;
    logic [2:0]       chunk_n;
    logic [2:0]       j_m1;
    logic [12:0]      off_step_rd;

    // shared address adder and end-of-store compare
    assign sum      = SUM_W'(add_a) + SUM_W'(add_b);
    assign past_end = sum > SUM_W'(MEM_BYTES);

    assign op_block  = (r_req == REQ_COPY) || (r_req == REQ_MOVE) || (r_req == REQ_FILL);
    assign op_single = (r_req == REQ_WRITE) || (r_req == REQ_READ);
    assign op_nop    = (!op_block && !op_single) || (op_block && (r_len == 13'd0));
    assign go_bwd    = (r_req == REQ_MOVE) && (r_dst > r_src) && (SUM_W'(r_dst) < sum);
    assign chunk_n   = r_grp ? 3'(GROUP_BYTES) : 3'd1;
    assign j_m1      = r_j - 3'd1;
    assign off_step_rd = r_bwd ? (r_rd_off - 13'd1) : (r_rd_off + 13'd1);

    always_comb begin
        add_a = (r_state inside {S_CHK2, S_RD}) ? r_src : r_dst;
        case (r_state)
            S_CHK1:       add_b = op_single ? 13'd1 : r_len;
            S_CHK2:       add_b = r_len;
            S_RD:         add_b = r_rd_off;
            S_WR, S_FILL: add_b = r_wr_off;
            default:      add_b = 13'd0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == AW'(MEM_BYTES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) n_state = S_CHK1;
            end
            S_CHK1: begin
                if (op_nop || past_end)      n_state = S_DONE;
                else if (r_req == REQ_FILL)  n_state = S_FILL;
                else if (r_req == REQ_WRITE) n_state = S_WB;
                else if (r_req == REQ_READ)  n_state = S_RB;
                else                         n_state = S_CHK2;
            end
            S_CHK2: begin
                if (past_end || ((r_req == REQ_MOVE) && (r_dst == r_src))) n_state = S_DONE;
                else                                                       n_state = S_RD;
            end
            S_RD: begin
                if (r_j == chunk_n) n_state = S_WR;
            end
            S_WR: begin
                if (r_j == chunk_n - 3'd1) n_state = (r_left == 13'd1) ? S_DONE : S_RD;
            end
            S_FILL: begin
                if (r_left == 13'd1) n_state = S_DONE;
            end
            S_RB:   n_state = S_RBW;
            S_RBW:  n_state = S_DONE;
            S_WB:   n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req_type;
                        r_dst   <= i_dst_addr;
                        r_src   <= i_src_addr;
                        r_len   <= i_length;
                        r_fill  <= i_fill_byte;
                        r_wbyte <= i_write_byte;
                        r_res   <= '0;
                    end
                end
                S_CHK1: begin
                    r_wr_off <= 13'd0;
                    r_left   <= r_len;
                    if (!op_nop && past_end) r_res.status <= 1'b1;
                end
                S_CHK2: begin
                    if (past_end) r_res.status <= 1'b1;
                    r_bwd    <= go_bwd;
                    r_rd_off <= go_bwd ? (r_len - 13'd1) : 13'd0;
                    r_wr_off <= go_bwd ? (r_len - 13'd1) : 13'd0;
                    r_left   <= r_len;
                    r_grp    <= !go_bwd && (r_len >= 13'(GROUP_BYTES));
                    r_j      <= 3'd0;
                end
                S_RD: begin
                    if (r_j != 3'd0) r_held[j_m1[GI_W-1:0]] <= i_mem_rdata;
                    if (r_j == chunk_n) begin
                        r_j <= 3'd0;
                    end else begin
                        r_j      <= r_j + 3'd1;
                        r_rd_off <= off_step_rd;
                    end
                end
                S_WR: begin
                    r_wr_off <= r_bwd ? (r_wr_off - 13'd1) : (r_wr_off + 13'd1);
                    r_left   <= r_left - 13'd1;
                    if (r_j == chunk_n - 3'd1) begin
                        r_j   <= 3'd0;
                        r_grp <= !r_bwd && ((r_left - 13'd1) >= 13'(GROUP_BYTES));
                    end else begin
                        r_j <= r_j + 3'd1;
                    end
                end
                S_FILL: begin
                    r_wr_off <= r_wr_off + 13'd1;
                    r_left   <= r_left - 13'd1;
                end
                S_RBW: begin
                    r_res.read_data <= i_mem_rdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_mem_we    = (r_state inside {S_CLR, S_WR, S_FILL, S_WB});
        o_mem_waddr = (r_state == S_CLR) ? r_clr : sum[AW-1:0];
        case (r_state)
            S_WR:    o_mem_wdata = r_held[r_j[GI_W-1:0]];
            S_FILL:  o_mem_wdata = r_fill;
            S_WB:    o_mem_wdata = r_wbyte;
            default: o_mem_wdata = 8'd0;
        endcase
        o_mem_re    = ((r_state == S_RD) && (r_j != chunk_n)) || (r_state == S_RB);
        o_mem_raddr = sum[AW-1:0];
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    a_accept_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_CHK1))
        else $error("accepted beat did not start range check");

    a_left_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_WR || r_state == S_FILL) |-> (r_left != 13'd0))
        else $error("byte walk running with nothing left");

    a_group_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD && r_grp) |-> (r_left >= 13'(GROUP_BYTES)))
        else $error("group started past the end of the range");

    a_bwd_bytewise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD || r_state == S_WR) && r_bwd) |-> !r_grp)
        else $error("backward move using groups");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> !o_mem_re)
        else $error("store read and written in the same cycle");

endmodule

`default_nettype wire
